[sv/bsdc_pkg.sv]
// Package for the button scan / double-click unit: payload structs, event
// kinds, register indexes and the microcode table of the scan sequencer.
// No dependencies.
package bsdc_pkg;

    localparam int CONTROL_COUNT = 8;
    localparam int KEY_COUNT     = 16;

    localparam int CTL_IDX_W = 3;
    localparam int IDX_W     = 4;

    localparam logic [15:0] CLICK_WINDOW_RESET_MS = 16'd300;

    // Event kinds
    localparam logic [2:0] KIND_PRESS       = 3'd0;
    localparam logic [2:0] KIND_DOUBLE      = 3'd1;
    localparam logic [2:0] KIND_RELEASE     = 3'd2;
    localparam logic [2:0] KIND_KEY_PRESS   = 3'd3;
    localparam logic [2:0] KIND_KEY_RELEASE = 3'd4;
    localparam logic [2:0] KIND_BOOTSEL     = 3'd5;

    // Configuration register indexes
    localparam logic REG_CLICK_WINDOW = 1'b0;
    localparam logic REG_DC_ENABLE    = 1'b1;

    typedef struct packed {
        logic [31:0] time_ms;
        logic [7:0]  control_levels;
        logic [15:0] key_levels;
    } poll_t;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [3:0] event_index;
        logic       last_event;
    } evt_t;

    // Event handed from the sequencer to the output queue
    typedef struct packed {
        logic       push;
        logic       flush;
        logic [2:0] kind;
        logic [3:0] index;
    } evt_req_t;

    // Microcode operations
    localparam logic [2:0] OP_WAIT   = 3'd0;
    localparam logic [2:0] OP_EXPIRE = 3'd1;
    localparam logic [2:0] OP_CTL    = 3'd2;
    localparam logic [2:0] OP_BOOT   = 3'd3;
    localparam logic [2:0] OP_KEY    = 3'd4;
    localparam logic [2:0] OP_FLUSH  = 3'd5;

    // Jump conditions
    localparam logic [1:0] COND_ALWAYS   = 2'd0;
    localparam logic [1:0] COND_POLL     = 2'd1;
    localparam logic [1:0] COND_IDX_LAST = 2'd2;

    localparam int STEP_W = 3;

    typedef struct packed {
        logic [2:0]        op;
        logic [1:0]        cond;
        logic [STEP_W-1:0] next;
    } ucode_t;

    localparam logic [STEP_W-1:0] STEP_WAIT   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_EXPIRE = 3'd1;
    localparam logic [STEP_W-1:0] STEP_CTL    = 3'd2;
    localparam logic [STEP_W-1:0] STEP_BOOT   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_KEY    = 3'd4;
    localparam logic [STEP_W-1:0] STEP_FLUSH  = 3'd5;

    // Scan program: one control word per step
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        begin
            unique case (step)
                STEP_WAIT:   w = '{op: OP_WAIT,   cond: COND_POLL,     next: STEP_EXPIRE};
                STEP_EXPIRE: w = '{op: OP_EXPIRE, cond: COND_ALWAYS,   next: STEP_CTL};
                STEP_CTL:    w = '{op: OP_CTL,    cond: COND_IDX_LAST, next: STEP_BOOT};
                STEP_BOOT:   w = '{op: OP_BOOT,   cond: COND_ALWAYS,   next: STEP_KEY};
                STEP_KEY:    w = '{op: OP_KEY,    cond: COND_IDX_LAST, next: STEP_FLUSH};
                STEP_FLUSH:  w = '{op: OP_FLUSH,  cond: COND_ALWAYS,   next: STEP_WAIT};
                default:     w = '{op: OP_WAIT,   cond: COND_ALWAYS,   next: STEP_WAIT};
            endcase
            return w;
        end
    endfunction

endpackage

[sv/bsdc_evt_queue.sv]
// Output side of the button scan unit: one held event plus the output
// register, so the last event of a poll can be marked. Uses bsdc_pkg.
module bsdc_evt_queue import bsdc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  evt_req_t req,
    output logic     req_ready,
    output logic     evt_valid,
    input  logic     evt_stall,
    output evt_t     evt
);

    logic       hold_valid_reg, hold_valid_next;
    logic [2:0] hold_kind_reg, hold_kind_next;
    logic [3:0] hold_index_reg, hold_index_next;
    logic       out_valid_reg, out_valid_next;
    evt_t       out_reg, out_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !evt_stall;
    assign req_ready = !hold_valid_reg || out_free;

    // Move the held event out when a new one arrives or the poll ends
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_kind_next  = hold_kind_reg;
        hold_index_next = hold_index_reg;
        out_valid_next  = out_valid_reg && evt_stall;
        out_next        = out_reg;
        if ((req.push || req.flush) && req_ready)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next = '{event_kind: hold_kind_reg, event_index: hold_index_reg,
                             last_event: req.flush};
            end
            hold_valid_next = req.push;
            if (req.push)
            begin
                hold_kind_next  = req.kind;
                hold_index_next = req.index;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        hold_kind_reg  <= hold_kind_next;
        hold_index_reg <= hold_index_next;
        out_reg        <= out_next;
    end

    assign evt_valid = out_valid_reg;
    assign evt       = out_reg;

endmodule

[sv/button_scan_double_click_unit.sv]
// Top level of the button scan / double-click unit: microcoded scan
// sequencer and datapath. Depends on bsdc_pkg and bsdc_evt_queue.
//
//  channel | signals                          | direction | transaction
//  poll    | poll_valid, poll_stall, poll     | in        | one poll sample
//  evt     | evt_valid, evt_stall, evt        | out       | one event
//  cfg     | cfg_valid, cfg_ready, cfg_index, | in        | one register write
//          | cfg_data                         |           |
//
// From acceptance to the next free slot a poll runs through one wait step,
// one expiry step, one step per control (8), one bootsel step, one step per
// key (16) and one flush step, set by the microcode step counter.
// A step with an event stalls while the output is stalled and the queue is full.
// Reset clears the scan history, the click state and the registers to defaults.
// Configuration writes are taken in every cycle.
module button_scan_double_click_unit import bsdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        poll_valid,
    output logic        poll_stall,
    input  poll_t       poll,
    output logic        evt_valid,
    input  logic        evt_stall,
    output evt_t        evt,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [STEP_W-1:0]    step_reg, step_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [15:0]          window_reg;
    logic [7:0]           dc_enable_reg;
    logic [7:0]           prev_ctl_reg, prev_ctl_next;
    logic [15:0]          prev_key_reg, prev_key_next;
    logic [CTL_IDX_W-1:0] pending_reg, pending_next;
    logic [31:0]          start_reg, start_next;
    logic [1:0]           count_reg, count_next;
    logic [31:0]          now_reg;
    logic [7:0]           ctl_reg;
    logic [15:0]          keys_reg;

    ucode_t   uw;
    evt_req_t req;
    logic     req_ready;
    logic     go;
    logic     idx_last;
    logic     jump;
    logic [31:0] elapsed;
    logic     expired;
    logic     in_window;
    logic     was_up;
    logic     is_up;

    assign uw         = ucode_rom(step_reg);
    assign poll_stall = (uw.op != OP_WAIT);
    assign cfg_ready  = 1'b1;

    // Elapsed time since the click window opened
    assign elapsed   = now_reg - start_reg;
    assign expired   = elapsed > {16'd0, window_reg};
    assign in_window = elapsed < {16'd0, window_reg};

    // Select the level bits of the scanned control or key
    always_comb
    begin
        if (uw.op == OP_KEY)
        begin
            was_up   = prev_key_reg[idx_reg];
            is_up    = keys_reg[idx_reg];
            idx_last = (idx_reg == IDX_W'(KEY_COUNT - 1));
        end
        else
        begin
            was_up   = prev_ctl_reg[idx_reg[CTL_IDX_W-1:0]];
            is_up    = ctl_reg[idx_reg[CTL_IDX_W-1:0]];
            idx_last = (idx_reg == IDX_W'(CONTROL_COUNT - 1));
        end
    end

    // Datapath for the current microcode operation
    always_comb
    begin
        req           = '{push: 1'b0, flush: 1'b0, kind: KIND_PRESS, index: '0};
        prev_ctl_next = prev_ctl_reg;
        prev_key_next = prev_key_reg;
        pending_next  = pending_reg;
        start_next    = start_reg;
        count_next    = count_reg;
        go            = 1'b1;
        unique case (uw.op)
            OP_WAIT:
            begin
                go = poll_valid;
            end
            OP_EXPIRE:
            begin
                if (expired)
                begin
                    req.push   = (count_reg != 2'd0);
                    req.kind   = (count_reg >= 2'd2) ? KIND_DOUBLE : KIND_PRESS;
                    req.index  = {1'b0, pending_reg};
                    count_next = 2'd0;
                end
            end
            OP_CTL:
            begin
                req.index = idx_reg;
                if (was_up && !is_up)
                begin
                    if (dc_enable_reg[idx_reg[CTL_IDX_W-1:0]])
                    begin
                        if (in_window && pending_reg == idx_reg[CTL_IDX_W-1:0])
                        begin
                            if (count_reg != 2'd3)
                                count_next = count_reg + 2'd1;
                        end
                        else
                        begin
                            start_next = now_reg;
                            count_next = 2'd1;
                        end
                    end
                    else
                    begin
                        req.push = 1'b1;
                        req.kind = KIND_PRESS;
                    end
                    pending_next = idx_reg[CTL_IDX_W-1:0];
                end
                else if (!was_up && is_up)
                begin
                    req.push = 1'b1;
                    req.kind = KIND_RELEASE;
                end
                prev_ctl_next[idx_reg[CTL_IDX_W-1:0]] = is_up;
            end
            OP_BOOT:
            begin
                req.push = !prev_ctl_reg[0] && !prev_ctl_reg[2] && !prev_ctl_reg[4];
                req.kind = KIND_BOOTSEL;
            end
            OP_KEY:
            begin
                req.index = idx_reg;
                if (was_up && !is_up)
                begin
                    req.push = 1'b1;
                    req.kind = KIND_KEY_PRESS;
                end
                else if (!was_up && is_up)
                begin
                    req.push = 1'b1;
                    req.kind = KIND_KEY_RELEASE;
                end
                prev_key_next[idx_reg] = is_up;
            end
            OP_FLUSH:
            begin
                req.flush = 1'b1;
            end
            default:
            begin
                go = 1'b1;
            end
        endcase
        // Stall the step while the queue cannot take the event
        if ((req.push || req.flush) && !req_ready)
            go = 1'b0;
    end

    // Advance the step counter and the scan index
    always_comb
    begin
        unique case (uw.cond)
            COND_POLL:     jump = poll_valid;
            COND_IDX_LAST: jump = idx_last;
            default:       jump = 1'b1;
        endcase
        step_next = step_reg;
        idx_next  = idx_reg;
        if (go)
        begin
            if (jump)
            begin
                step_next = uw.next;
                idx_next  = '0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    // Hold scan and click state; commit only on a step that goes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_WAIT;
            idx_reg       <= '0;
            window_reg    <= CLICK_WINDOW_RESET_MS;
            dc_enable_reg <= '0;
            prev_ctl_reg  <= '1;
            prev_key_reg  <= '1;
            pending_reg   <= '0;
            start_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            step_reg <= step_next;
            idx_reg  <= idx_next;
            if (go)
            begin
                prev_ctl_reg <= prev_ctl_next;
                prev_key_reg <= prev_key_next;
                pending_reg  <= pending_next;
                start_reg    <= start_next;
                count_reg    <= count_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_CLICK_WINDOW: window_reg    <= cfg_data;
                    REG_DC_ENABLE:    dc_enable_reg <= cfg_data[7:0];
                    default:          window_reg    <= window_reg;
                endcase
            end
        end
    end

    // Capture the poll transaction
    always_ff @(posedge clk)
    begin
        if (poll_valid && !poll_stall)
        begin
            now_reg  <= poll.time_ms;
            ctl_reg  <= poll.control_levels;
            keys_reg <= poll.key_levels;
        end
    end

    bsdc_evt_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_ready (req_ready),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

endmodule

[tb/sv/button_scan_double_click_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for button_scan_double_click_unit: directed and random polls
// against a behavioral scan and click-window predictor, with random poll gaps and output stalls.
// Depends on bsdc_pkg and the unit's RTL.
module button_scan_double_click_unit_tb;
    import bsdc_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_POLLS   = 72;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        poll_valid;
    logic        poll_stall;
    poll_t       poll;
    logic        evt_valid;
    logic        evt_stall;
    evt_t        evt;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    // Predictor copy of registers and scan state
    logic [15:0] win_ms;
    logic [7:0]  dc_mask;
    logic [7:0]  seen_ctl;
    logic [15:0] seen_keys;
    logic [2:0]  click_ctl;
    logic [31:0] click_t0;
    logic [1:0]  clicks;
    evt_t        scan_events_due[$];

    // Last poll sent, basis of the random walk
    logic [31:0] stim_time;
    logic [7:0]  stim_ctl;
    logic [15:0] stim_keys;

    bit idle_on = 1'b1;
    int hold_left = 0;
    int errors = 0;
    int polls_sent = 0;
    int eventful_polls = 0;
    int events_seen = 0;
    int doubles_seen = 0;
    int reg_writes = 0;
    int quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    button_scan_double_click_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .poll_valid (poll_valid),
        .poll_stall (poll_stall),
        .poll       (poll),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt        (evt),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    task automatic note_mismatch(input string what);
        errors++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    function automatic evt_t mk_evt(input logic [2:0] kind, input logic [3:0] idx);
        evt_t e;
        e.event_kind  = kind;
        e.event_index = idx;
        e.last_event  = 1'b0;
        return e;
    endfunction

    function automatic poll_t mk_poll(input logic [31:0] t, input logic [7:0] c,
                                      input logic [15:0] k);
        poll_t p;
        p.time_ms        = t;
        p.control_levels = c;
        p.key_levels     = k;
        return p;
    endfunction

    // Advance the predictor by one poll and queue the events it owes
    task automatic scan_poll_events(input poll_t p);
        evt_t        found[$];
        logic [31:0] elapsed;
        logic        was_up;
        logic        is_up;
        elapsed = p.time_ms - click_t0;
        // close an expired click window
        if (elapsed > {16'd0, win_ms})
        begin
            if (clicks >= 2'd2)
                found.push_back(mk_evt(KIND_DOUBLE, {1'b0, click_ctl}));
            else if (clicks == 2'd1)
                found.push_back(mk_evt(KIND_PRESS, {1'b0, click_ctl}));
            clicks = 2'd0;
        end
        // control edges, counting clicks on enabled controls
        for (int i = 0; i < CONTROL_COUNT; i++)
        begin
            was_up = seen_ctl[i];
            is_up  = p.control_levels[i];
            if (was_up && !is_up)
            begin
                if (dc_mask[i])
                begin
                    elapsed = p.time_ms - click_t0;
                    if (elapsed < {16'd0, win_ms} && click_ctl == 3'(i))
                    begin
                        if (clicks != 2'd3)
                            clicks = clicks + 2'd1;
                    end
                    else
                    begin
                        click_t0 = p.time_ms;
                        clicks   = 2'd1;
                    end
                end
                else
                    found.push_back(mk_evt(KIND_PRESS, 4'(i)));
                click_ctl = 3'(i);
            end
            else if (!was_up && is_up)
                found.push_back(mk_evt(KIND_RELEASE, 4'(i)));
            seen_ctl[i] = is_up;
        end
        // bootsel chord: controls 0, 2 and 4 held
        if ((seen_ctl & 8'h15) == 8'h00)
            found.push_back(mk_evt(KIND_BOOTSEL, 4'd0));
        // key edges
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            was_up = seen_keys[i];
            is_up  = p.key_levels[i];
            if (was_up && !is_up)
                found.push_back(mk_evt(KIND_KEY_PRESS, 4'(i)));
            else if (!was_up && is_up)
                found.push_back(mk_evt(KIND_KEY_RELEASE, 4'(i)));
            seen_keys[i] = is_up;
        end
        if (found.size() > 0)
        begin
            found[found.size() - 1].last_event = 1'b1;
            eventful_polls++;
        end
        foreach (found[j])
            scan_events_due.push_back(found[j]);
    endtask

    // Offer one poll, with a random gap first, and predict on acceptance
    task automatic send_poll(input poll_t p);
        int gap;
        gap = 0;
        if (idle_on)
            while ($urandom_range(99) < 30)
                gap++;
        if (gap > 0)
        begin
            poll_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        poll       <= p;
        poll_valid <= 1'b1;
        @(posedge clk);
        while (poll_stall)
            @(posedge clk);
        scan_poll_events(p);
        polls_sent++;
        stim_time = p.time_ms;
        stim_ctl  = p.control_levels;
        stim_keys = p.key_levels;
    endtask

    // Stop offering, wait for every owed event, then let the scan finish
    task automatic drain_and_settle();
        poll_valid <= 1'b0;
        @(posedge clk);
        while (scan_events_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == REG_CLICK_WINDOW)
            win_ms = data;
        else
            dc_mask = data[7:0];
        reg_writes++;
    endtask

    task automatic configure(input logic [15:0] window, input logic [15:0] enable_word);
        drain_and_settle();
        write_reg(REG_CLICK_WINDOW, window);
        write_reg(REG_DC_ENABLE, enable_word);
    endtask

    // Mostly single-control toggles at click-scale time steps, some noise
    function automatic poll_t random_poll();
        poll_t p;
        int    span;
        int    pick;
        pick = $urandom_range(99);
        span = int'(win_ms) + 1;
        p = mk_poll(stim_time, stim_ctl, stim_keys);
        if (pick < 75)
        begin
            if ($urandom_range(3) == 0)
                p.time_ms = stim_time + 32'($urandom_range(2 * span, span));
            else
                p.time_ms = stim_time + 32'($urandom_range(span - 1, 0));
            p.control_levels[$urandom_range(CONTROL_COUNT - 1)] ^= 1'b1;
            if ($urandom_range(1) == 1)
                p.key_levels[$urandom_range(KEY_COUNT - 1)] ^= 1'b1;
            // now and then hold the bootsel chord
            if ($urandom_range(19) == 0)
                p.control_levels &= ~8'h15;
        end
        else if (pick < 90)
        begin
            p.time_ms = stim_time + 32'($urandom_range(3));
            p.control_levels ^= 8'($urandom);
            p.key_levels ^= 16'($urandom);
        end
        else
        begin
            p.time_ms        = $urandom;
            p.control_levels = 8'($urandom);
            p.key_levels     = 16'($urandom);
        end
        return p;
    endfunction

    // Every edge kind with default registers, extremes of time and levels
    task automatic test_plain_edges();
        send_poll(mk_poll(32'd10, 8'h00, 16'h0000));
        send_poll(mk_poll(32'd20, 8'h00, 16'h0000));
        send_poll(mk_poll(32'hFFFF_FFFF, 8'hFF, 16'hFFFF));
    endtask

    // Click counting: saturation, single press, restart on another control, boundaries
    task automatic test_click_counting();
        configure(16'd300, 16'hA5FF);
        send_poll(mk_poll(32'd1000, 8'hFE, 16'hFFFF));
        send_poll(mk_poll(32'd1050, 8'hFF, 16'hFFFF));
        send_poll(mk_poll(32'd1100, 8'hFE, 16'hFFFF));
        send_poll(mk_poll(32'd1150, 8'hFF, 16'hFFFF));
        send_poll(mk_poll(32'd1200, 8'hFE, 16'hFFFF));
        send_poll(mk_poll(32'd1250, 8'hFF, 16'hFFFF));
        send_poll(mk_poll(32'd1290, 8'hFE, 16'hFFFF));
        send_poll(mk_poll(32'd1301, 8'hFF, 16'hFFFF));
        send_poll(mk_poll(32'd2000, 8'hFD, 16'hFFFF));
        send_poll(mk_poll(32'd2050, 8'hF9, 16'hFFFF));
        send_poll(mk_poll(32'd2400, 8'hFF, 16'hFFFF));
        // elapsed equal to the window neither expires nor counts
        send_poll(mk_poll(32'd4000, 8'hEF, 16'hFFFF));
        send_poll(mk_poll(32'd4300, 8'hFF, 16'hFFFF));
        send_poll(mk_poll(32'd4300, 8'hEF, 16'hFFFF));
        send_poll(mk_poll(32'd4601, 8'hFF, 16'hFFFF));
    endtask

    // Zero window: clicks never accumulate, a later time expires
    task automatic test_zero_window();
        configure(16'd0, 16'h00FF);
        send_poll(mk_poll(32'd5000, 8'hFE, 16'hFFFF));
        send_poll(mk_poll(32'd5000, 8'hFF, 16'hFFFF));
        send_poll(mk_poll(32'd5000, 8'hFE, 16'hFFFF));
        send_poll(mk_poll(32'd5001, 8'hFF, 16'hFFFF));
    endtask

    // Double click across the 32-bit time wrap
    task automatic test_time_wrap();
        configure(16'd300, 16'h00FF);
        send_poll(mk_poll(32'hFFFF_FF00, 8'hFE, 16'hFFFF));
        send_poll(mk_poll(32'hFFFF_FF80, 8'hFF, 16'hFFFF));
        send_poll(mk_poll(32'h0000_0010, 8'hFE, 16'hFFFF));
        send_poll(mk_poll(32'h0000_0200, 8'hFF, 16'hFFFF));
    endtask

    // Random polls under several register settings
    task automatic test_random_polls();
        int start;
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: configure(16'd300, 16'h0000);
                1: configure(16'd1, 16'h00FF);
                2: configure(16'd65535, 16'h000F);
                default: configure(16'($urandom_range(600, 20)), 16'($urandom));
            endcase
            // one phase runs with no idling on either side
            idle_on = (ph != 1);
            start = eventful_polls;
            while (eventful_polls - start < PHASE_POLLS)
                send_poll(random_poll());
        end
        idle_on = 1'b1;
    endtask

    // Hold the output while key storms keep coming, then drain
    task automatic test_output_backpressure();
        hold_left = HOLD_CYCLES;
        for (int n = 0; n < 16; n++)
            send_poll(mk_poll(stim_time + 32'd5, stim_ctl, ~stim_keys));
        drain_and_settle();
    endtask

    // Receiver: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            evt_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (idle_on)
            evt_stall <= ($urandom_range(99) < 30);
        else
            evt_stall <= 1'b0;
    end

    // Compare each event transaction with the oldest owed one
    always @(posedge clk)
    begin : check_event
        evt_t want;
        if (rst_n && evt_valid && !evt_stall)
        begin
            events_seen++;
            if (evt.event_kind == KIND_DOUBLE)
                doubles_seen++;
            if (scan_events_due.size() == 0)
                note_mismatch($sformatf("unexpected event kind %0d index %0d last %0b",
                                        evt.event_kind, evt.event_index, evt.last_event));
            else
            begin
                want = scan_events_due.pop_front();
                if (evt.event_kind !== want.event_kind ||
                    evt.event_index !== want.event_index ||
                    evt.last_event !== want.last_event)
                    note_mismatch($sformatf("got kind %0d index %0d last %0b, want %0d %0d %0b",
                                            evt.event_kind, evt.event_index, evt.last_event,
                                            want.event_kind, want.event_index,
                                            want.last_event));
            end
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (poll_valid && !poll_stall) || (evt_valid && !evt_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        poll_valid <= 1'b0;
        poll       <= '0;
        evt_stall  <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_CLICK_WINDOW;
        cfg_data   <= '0;
        win_ms     = CLICK_WINDOW_RESET_MS;
        dc_mask    = 8'h00;
        seen_ctl   = 8'hFF;
        seen_keys  = 16'hFFFF;
        click_ctl  = 3'd0;
        click_t0   = 32'd0;
        clicks     = 2'd0;
        stim_time  = 32'd0;
        stim_ctl   = 8'hFF;
        stim_keys  = 16'hFFFF;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_edges();
        test_click_counting();
        test_zero_window();
        test_time_wrap();
        test_random_polls();
        test_output_backpressure();
        drain_and_settle();

        if (scan_events_due.size() != 0)
            note_mismatch($sformatf("%0d events never arrived", scan_events_due.size()));
        $display("Run covered %0d polls (%0d with events) and %0d register writes;",
                 polls_sent, eventful_polls, reg_writes);
        $display("checked %0d events, %0d of them double presses, %0d mismatches.",
                 events_seen, doubles_seen, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
